>>> src/hsg_pkg.sv
// Shared types and constants for the handheld sound generator.
// Used by hsg_core, the top level and the port checker; no dependencies.
`timescale 1ns / 1ps

package hsg_pkg;

   typedef enum logic [1:0] {
      KIND_REG  = 2'd0,
      KIND_TICK = 2'd1,
      KIND_MEM  = 2'd2,
      KIND_NONE = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_NOISE = 3'b010,
      ST_MIX   = 3'b100
   } state_type;

   localparam logic [1:0] CSR_MUTE  = 2'd0;
   localparam logic [1:0] CSR_SWAP  = 2'd1;
   localparam logic [1:0] CSR_DECR  = 2'd2;
   localparam logic [3:0] MUTE_RESET = 4'hf;
   localparam logic [15:0] DECR_RESET = 16'd1041;

   localparam logic [12:0] TONE_LO  = 13'h10;
   localparam logic [12:0] TONE_HI  = 13'h17;
   localparam logic [12:0] DMA_LO   = 13'h18;
   localparam logic [12:0] DMA_HI   = 13'h1c;
   localparam logic [12:0] NOISE_LO = 13'h28;
   localparam logic [12:0] NOISE_HI = 13'h2a;

   localparam logic [16:0] PHASE_ONE = 17'h1000;

   // sequencer controls to the datapath
   typedef struct packed {
      logic reg_wr;
      logic tick;
      logic shift;
      logic mix;
   } ctl_type;

   // first member lands in the top bits, so left sits in [7:0]
   typedef struct packed {
      logic [5:0] noise;
      logic [5:0] sample;
      logic [5:0] tone1;
      logic [5:0] tone0;
      logic [7:0] right;
      logic [7:0] left;
   } result_type;

   function automatic logic [10:0] tone_thr(input logic [1:0] wave, input logic [10:0] sz);
      logic [15:0] prod;
      begin
         prod = 16'd0;
         case (wave)
            2'd0: prod = 16'(sz) * 16'd28;
            2'd1: prod = 16'(sz) * 16'd24;
            2'd2: prod = {sz, 5'd0} >> 1;
            default: prod = {sz, 5'd0} >> 2;
         endcase
         tone_thr = prod[15:5];
      end
   endfunction

endpackage

>>> src/hsg_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module hsg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 131072
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> src/hsg_core.sv
// Sound datapath: tone, noise and DMA state, register decode, tick mixing.
// Depends on hsg_pkg; sample bytes arrive from the sample RAM in the cycle after mem_addr.
`timescale 1ns / 1ps

module hsg_core #(
   parameter int AW = 17
) (
   input  logic                  clock,
   input  logic                  reset,
   input  hsg_pkg::ctl_type      ctl,
   input  logic [12:0]           addr,
   input  logic [7:0]            data,
   input  logic [3:0]            mute_mask,
   input  logic                  swap_stereo,
   input  logic [15:0]           decr_period,
   input  logic [7:0]            rd_data,
   output logic [AW-1:0]         mem_addr,
   output logic                  noise_busy,
   output hsg_pkg::result_type   result
);
   // tone state
   logic [7:0]  b0_ff [2], b0_in [2];
   logic [2:0]  b1_ff [2], b1_in [2];
   logic        p_on_ff [2], p_on_in [2];
   logic [1:0]  p_wave_ff [2], p_wave_in [2];
   logic [3:0]  p_vol_ff [2], p_vol_in [2];
   logic [10:0] p_size_ff [2], p_size_in [2];
   logic        a_on_ff [2], a_on_in [2];
   logic [1:0]  a_wave_ff [2], a_wave_in [2];
   logic [3:0]  a_vol_ff [2], a_vol_in [2];
   logic [10:0] a_pos_ff [2], a_pos_in [2];
   logic [10:0] a_size_ff [2], a_size_in [2];
   logic [8:0]  t_len_ff [2], t_len_in [2];
   // noise state
   logic        n_on_ff, n_on_in, n_play_ff, n_play_in;
   logic        n_left_ff, n_left_in, n_right_ff, n_right_in;
   logic        n_shift_hi_ff, n_shift_hi_in;
   logic [3:0]  n_vol_ff, n_vol_in;
   logic [15:0] n_step_ff, n_step_in;
   logic [16:0] n_phase_ff, n_phase_in;
   logic [8:0]  n_len_ff, n_len_in;
   logic [14:0] lfsr_ff, lfsr_in;
   logic        n_bit_ff, n_bit_in;
   // dma state
   logic [7:0]  d_start_lo_ff, d_start_lo_in, d_start_hi_ff, d_start_hi_in;
   logic [8:0]  d_size_ff, d_size_in;
   logic [3:0]  d_step_ff, d_step_in;
   logic        d_left_ff, d_left_in, d_right_ff, d_right_in, d_on_ff, d_on_in;
   logic [2:0]  d_bank_ff, d_bank_in;
   logic [18:0] d_pos_ff, d_pos_in;
   logic [16:0] decr_cnt_ff, decr_cnt_in;
   // tick partial results held for the mix step
   logic [7:0]  left_ff, left_in, right_ff, right_in;
   logic [5:0]  lv0_ff, lv0_in, lv1_ff, lv1_in, lv3_ff, lv3_in;
   logic        d_act_ff, d_act_in, d_win_ff, d_win_in, d_odd_ff, d_odd_in;
   logic [AW-1:0] mem_addr_ff, mem_addr_in;

   logic [5:0] dma_lvl;

   always_comb begin
      logic        t;
      logic [10:0] psz, thr, pos;
      logic [10:0] raw;
      logic [5:0]  s;
      logic [7:0]  lsum, rsum;
      logic [15:0] ad;
      logic [16:0] full;
      logic        fb;
      for (int j = 0; j < 2; j++) begin
         b0_in[j] = b0_ff[j];       b1_in[j] = b1_ff[j];
         p_on_in[j] = p_on_ff[j];   p_wave_in[j] = p_wave_ff[j];
         p_vol_in[j] = p_vol_ff[j]; p_size_in[j] = p_size_ff[j];
         a_on_in[j] = a_on_ff[j];   a_wave_in[j] = a_wave_ff[j];
         a_vol_in[j] = a_vol_ff[j]; a_pos_in[j] = a_pos_ff[j];
         a_size_in[j] = a_size_ff[j]; t_len_in[j] = t_len_ff[j];
      end
      n_on_in = n_on_ff; n_play_in = n_play_ff; n_left_in = n_left_ff;
      n_right_in = n_right_ff; n_shift_hi_in = n_shift_hi_ff; n_vol_in = n_vol_ff;
      n_step_in = n_step_ff; n_phase_in = n_phase_ff; n_len_in = n_len_ff;
      lfsr_in = lfsr_ff; n_bit_in = n_bit_ff;
      d_start_lo_in = d_start_lo_ff; d_start_hi_in = d_start_hi_ff;
      d_size_in = d_size_ff; d_step_in = d_step_ff; d_left_in = d_left_ff;
      d_right_in = d_right_ff; d_on_in = d_on_ff; d_bank_in = d_bank_ff;
      d_pos_in = d_pos_ff; decr_cnt_in = decr_cnt_ff;
      left_in = left_ff; right_in = right_ff;
      lv0_in = lv0_ff; lv1_in = lv1_ff; lv3_in = lv3_ff;
      d_act_in = d_act_ff; d_win_in = d_win_ff; d_odd_in = d_odd_ff;
      mem_addr_in = mem_addr_ff;
      t = addr[2];
      psz = '0; thr = '0; pos = '0; raw = '0; s = '0;
      lsum = '0; rsum = '0; ad = '0; full = '0; fb = 1'b0;

      if (ctl.reg_wr) begin
         if (addr >= hsg_pkg::TONE_LO && addr <= hsg_pkg::TONE_HI) begin
            case (addr[1:0])
               2'd0, 2'd1: begin
                  if (addr[0]) b1_in[t] = data[2:0];
                  else         b0_in[t] = data;
                  raw = {b1_in[t], b0_in[t]};
                  psz = (raw == 11'd0) ? 11'd0 : 11'((12'(raw) + 12'd1) >> 1);
                  p_size_in[t] = psz;
                  if (t_len_ff[t] != 9'd0 || a_size_ff[t] == 11'd0 || psz == 11'd0) begin
                     a_size_in[t] = psz;
                     if (t_len_ff[t] == 9'd0) a_pos_in[t] = 11'd0;
                  end
               end
               2'd2: begin
                  p_on_in[t] = data[6];
                  p_wave_in[t] = data[5:4];
                  p_vol_in[t] = data[3:0];
                  if (!data[6] || a_size_ff[t] == 11'd0 || p_size_ff[t] == 11'd0) begin
                     a_on_in[t] = data[6];
                     a_wave_in[t] = data[5:4];
                     a_vol_in[t] = data[3:0];
                     a_size_in[t] = p_size_ff[t];
                     if (t_len_ff[t] == 9'd0) a_pos_in[t] = 11'd0;
                  end
               end
               default: begin
                  t_len_in[t] = 9'(data) + 9'd1;
                  a_size_in[t] = p_size_ff[t];
               end
            endcase
         end else if (addr >= hsg_pkg::DMA_LO && addr <= hsg_pkg::DMA_HI) begin
            case (addr[2:0])
               3'd0: d_start_lo_in = data;
               3'd1: d_start_hi_in = data;
               3'd2: d_size_in = (data == 8'd0) ? 9'h100 : 9'(data);
               3'd3: begin
                  d_step_in = 4'd8 >> data[1:0];
                  d_right_in = data[2];
                  d_left_in = data[3];
                  d_bank_in = data[6:4];
               end
               default: begin
                  d_on_in = data[7];
                  if (data[7]) d_pos_in = '0;
               end
            endcase
         end else if (addr >= hsg_pkg::NOISE_LO && addr <= hsg_pkg::NOISE_HI) begin
            case (addr[1:0])
               2'd0: begin
                  n_step_in = 16'h8000 >> data[7:4];
                  n_vol_in = data[3:0];
               end
               2'd1: n_len_in = 9'(data) + 9'd1;
               default: begin
                  n_shift_hi_in = data[0];
                  n_play_in = data[1];
                  n_right_in = data[2];
                  n_left_in = data[3];
                  n_on_in = data[4];
                  lfsr_in = 15'd1;
               end
            endcase
            n_phase_in = '0;
         end
      end

      if (ctl.tick) begin
         lv0_in = '0; lv1_in = '0; lv3_in = '0;
         for (int j = 0; j < 2; j++) begin
            if (a_size_ff[j] != 11'd0) begin
               if (a_on_ff[j] || t_len_ff[j] != 9'd0) begin
                  thr = hsg_pkg::tone_thr(a_wave_ff[j], a_size_ff[j]);
                  s = (a_pos_ff[j] < thr) ? {a_vol_ff[j], 2'b00} : 6'd0;
                  if (!mute_mask[3-j]) s = 6'd0;
                  if (swap_stereo) begin
                     if (j == 0) rsum = rsum + 8'(s);
                     else        lsum = lsum + 8'(s);
                  end else begin
                     lsum = lsum + 8'(s);
                     rsum = rsum + 8'(s);
                  end
                  if (j == 0) lv0_in = s;
                  else        lv1_in = s;
               end
               pos = a_pos_ff[j] + 11'd1;
               a_pos_in[j] = pos;
               if (pos >= a_size_ff[j]) begin
                  a_pos_in[j] = 11'd0;
                  if (p_on_ff[j]) begin
                     a_on_in[j] = 1'b1;
                     a_wave_in[j] = p_wave_ff[j];
                     a_vol_in[j] = p_vol_ff[j];
                     a_size_in[j] = p_size_ff[j];
                     p_on_in[j] = 1'b0;
                  end
               end
            end
         end
         if (n_on_ff && (n_play_ff || n_len_ff != 9'd0)) begin
            s = n_bit_ff ? {n_vol_ff, 2'b00} : 6'd0;
            if (!mute_mask[0]) s = 6'd0;
            if (n_left_ff)  lsum = lsum + 8'(s);
            if (n_right_ff) rsum = rsum + 8'(s);
            if (n_left_ff || n_right_ff) lv3_in = s;
            n_phase_in = n_phase_ff + 17'(n_step_ff);
         end
         left_in = lsum;
         right_in = rsum;
         // fetch address for this tick's nibble
         ad = {d_start_hi_ff, d_start_lo_ff} + 16'(d_pos_ff[18:6]);
         full = {d_bank_ff, ad[13:0]};
         mem_addr_in = full[AW-1:0];
         d_win_in = (ad[15:14] == 2'b10);
         d_odd_in = d_pos_ff[5];
         d_act_in = d_on_ff;
      end

      if (ctl.shift) begin
         n_bit_in = lfsr_ff[0];
         fb = lfsr_ff[1] ^ lfsr_ff[0];
         lfsr_in = {1'b0, lfsr_ff[14:1]} |
                   (n_shift_hi_ff ? (15'(fb) << 14) : (15'(fb) << 6));
         n_phase_in = n_phase_ff - hsg_pkg::PHASE_ONE;
      end

      if (ctl.mix) begin
         if (d_act_ff) begin
            d_pos_in = d_pos_ff + 19'(d_step_ff);
            if (d_pos_in >= {d_size_ff, 10'd0}) d_on_in = 1'b0;
         end
         if (decr_cnt_ff > 17'(decr_period)) begin
            decr_cnt_in = 17'd1;
            for (int j = 0; j < 2; j++) begin
               if (t_len_ff[j] != 9'd0) t_len_in[j] = t_len_ff[j] - 9'd1;
            end
            if (n_len_ff != 9'd0) n_len_in = n_len_ff - 9'd1;
         end else begin
            decr_cnt_in = decr_cnt_ff + 17'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < 2; j++) begin
            b0_ff[j] <= '0; b1_ff[j] <= '0;
            p_on_ff[j] <= 1'b0; p_wave_ff[j] <= '0; p_vol_ff[j] <= '0; p_size_ff[j] <= '0;
            a_on_ff[j] <= 1'b0; a_wave_ff[j] <= '0; a_vol_ff[j] <= '0;
            a_pos_ff[j] <= '0; a_size_ff[j] <= '0; t_len_ff[j] <= '0;
         end
         n_on_ff <= 1'b0; n_play_ff <= 1'b0; n_left_ff <= 1'b0; n_right_ff <= 1'b0;
         n_shift_hi_ff <= 1'b0; n_vol_ff <= '0; n_step_ff <= '0; n_phase_ff <= '0;
         n_len_ff <= '0; lfsr_ff <= '0; n_bit_ff <= 1'b0;
         d_start_lo_ff <= '0; d_start_hi_ff <= '0; d_size_ff <= '0; d_step_ff <= '0;
         d_left_ff <= 1'b0; d_right_ff <= 1'b0; d_on_ff <= 1'b0; d_bank_ff <= '0;
         d_pos_ff <= '0; decr_cnt_ff <= '0;
         d_act_ff <= 1'b0;
      end else begin
         for (int j = 0; j < 2; j++) begin
            b0_ff[j] <= b0_in[j]; b1_ff[j] <= b1_in[j];
            p_on_ff[j] <= p_on_in[j]; p_wave_ff[j] <= p_wave_in[j];
            p_vol_ff[j] <= p_vol_in[j]; p_size_ff[j] <= p_size_in[j];
            a_on_ff[j] <= a_on_in[j]; a_wave_ff[j] <= a_wave_in[j]; a_vol_ff[j] <= a_vol_in[j];
            a_pos_ff[j] <= a_pos_in[j]; a_size_ff[j] <= a_size_in[j]; t_len_ff[j] <= t_len_in[j];
         end
         n_on_ff <= n_on_in; n_play_ff <= n_play_in; n_left_ff <= n_left_in;
         n_right_ff <= n_right_in; n_shift_hi_ff <= n_shift_hi_in; n_vol_ff <= n_vol_in;
         n_step_ff <= n_step_in; n_phase_ff <= n_phase_in; n_len_ff <= n_len_in;
         lfsr_ff <= lfsr_in; n_bit_ff <= n_bit_in;
         d_start_lo_ff <= d_start_lo_in; d_start_hi_ff <= d_start_hi_in;
         d_size_ff <= d_size_in; d_step_ff <= d_step_in; d_left_ff <= d_left_in;
         d_right_ff <= d_right_in; d_on_ff <= d_on_in; d_bank_ff <= d_bank_in;
         d_pos_ff <= d_pos_in; decr_cnt_ff <= decr_cnt_in;
         d_act_ff <= d_act_in;
      end
   end

   // payload holding registers
   always_ff @(posedge clock) begin
      left_ff <= left_in; right_ff <= right_in;
      lv0_ff <= lv0_in; lv1_ff <= lv1_in; lv3_ff <= lv3_in;
      d_win_ff <= d_win_in; d_odd_ff <= d_odd_in;
      mem_addr_ff <= mem_addr_in;
   end

   always_comb begin
      logic [3:0] nib;
      nib = !d_win_ff ? 4'd0 : (d_odd_ff ? rd_data[3:0] : rd_data[7:4]);
      dma_lvl = mute_mask[1] ? {nib, 2'b00} : 6'd0;
      result.left = left_ff + ((d_act_ff && d_left_ff) ? 8'(dma_lvl) : 8'd0);
      result.right = right_ff + ((d_act_ff && d_right_ff) ? 8'(dma_lvl) : 8'd0);
      result.tone0 = lv0_ff;
      result.tone1 = lv1_ff;
      result.sample = (d_act_ff && (d_left_ff || d_right_ff)) ? dma_lvl : 6'd0;
      result.noise = lv3_ff;
   end

   assign mem_addr = mem_addr_ff;
   assign noise_busy = (n_phase_ff >= hsg_pkg::PHASE_ONE);
endmodule

>>> src/handheld_sound_generator.sv
// Handheld sound generator: two pulse tones, an LFSR noise source and a nibble-sample DMA
// player mixed to stereo. A tick moves from the idle state to the noise state, which makes
// the 0 to 8 LFSR shifts due that tick (one per cycle), then to the mix state; the sample
// RAM read overlaps the first noise-state cycle. The mix step waits while the previous
// result still sits unread in the output register; otherwise the result lands there and
// the next item is taken. Sample memory has no reset: bytes must be written before DMA
// plays them. Top level of the block; depends on hsg_pkg, hsg_ram and hsg_core.
`timescale 1ns / 1ps

module handheld_sound_generator #(
   parameter int SAMPLE_MEM_ADDR_BITS = 17
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [16:0] address, [24:17] data
   input  logic [1:0]  req_tuser,   // [1:0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] left_mix, [15:8] right_mix, [21:16] tone0_level, [27:22] tone1_level,
   // [33:28] sample_level, [39:34] noise_level
   output logic [39:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int AW = SAMPLE_MEM_ADDR_BITS;

   hsg_pkg::state_type  state_ff, state_in;
   hsg_pkg::ctl_type    ctl;
   hsg_pkg::result_type result;
   logic [39:0] rsp_data_ff, rsp_data_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [3:0]  mute_ff;
   logic        swap_ff;
   logic [15:0] period_ff;
   logic        accept, mem_wr, noise_busy;
   logic [AW-1:0] mem_addr;
   logic [7:0]  rd_data;

   assign req_tready = (state_ff == hsg_pkg::ST_IDLE);
   assign accept = req_tvalid && req_tready;
   assign mem_wr = accept && (req_tuser == hsg_pkg::KIND_MEM);

   always_comb begin
      state_in = state_ff;
      ctl = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      case (state_ff)
         hsg_pkg::ST_IDLE: begin
            if (accept && req_tuser == hsg_pkg::KIND_REG) ctl.reg_wr = 1'b1;
            if (accept && req_tuser == hsg_pkg::KIND_TICK) begin
               ctl.tick = 1'b1;
               state_in = hsg_pkg::ST_NOISE;
            end
         end
         hsg_pkg::ST_NOISE: begin
            // also covers the sample RAM read latency
            if (noise_busy) ctl.shift = 1'b1;
            else            state_in = hsg_pkg::ST_MIX;
         end
         hsg_pkg::ST_MIX: begin
            if (!rsp_valid_ff || rsp_tready) begin
               ctl.mix = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_data_in = result;
               state_in = hsg_pkg::ST_IDLE;
            end
         end
         default: state_in = hsg_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hsg_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mute_ff <= hsg_pkg::MUTE_RESET;
         swap_ff <= 1'b0;
         period_ff <= hsg_pkg::DECR_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         case (csr_paddr[3:2])
            hsg_pkg::CSR_MUTE: mute_ff <= csr_pwdata[3:0];
            hsg_pkg::CSR_SWAP: swap_ff <= csr_pwdata[0];
            hsg_pkg::CSR_DECR: period_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         hsg_pkg::CSR_MUTE: csr_prdata = {28'd0, mute_ff};
         hsg_pkg::CSR_SWAP: csr_prdata = {31'd0, swap_ff};
         hsg_pkg::CSR_DECR: csr_prdata = {16'd0, period_ff};
         default: csr_prdata = 32'd0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   hsg_ram #(
      .WIDTH(8),
      .DEPTH(2 ** AW)
   ) u_sample_ram (
      .clock  (clock),
      .wr_en  (mem_wr),
      .wr_addr(req_tdata[AW-1:0]),
      .wr_data(req_tdata[24:17]),
      .rd_addr(mem_addr),
      .rd_data(rd_data)
   );

   hsg_core #(
      .AW(AW)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .addr       (req_tdata[12:0]),
      .data       (req_tdata[24:17]),
      .mute_mask  (mute_ff),
      .swap_stereo(swap_ff),
      .decr_period(period_ff),
      .rd_data    (rd_data),
      .mem_addr   (mem_addr),
      .noise_busy (noise_busy),
      .result     (result)
   );
endmodule

>>> src/hsg_checker.sv
// Port-level checks for the handheld sound generator, bound to the top level.
// Depends on hsg_pkg for the item kind codes.
`timescale 1ns / 1ps

module hsg_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result item changed while stalled");

   // a non-tick item never creates a result
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser != hsg_pkg::KIND_TICK && !rsp_tvalid
      |=> !rsp_tvalid)
      else $error("result without a tick");

   a_left_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> 9'(rsp_tdata[7:0]) <= 9'(rsp_tdata[21:16]) + 9'(rsp_tdata[27:22])
                     + 9'(rsp_tdata[33:28]) + 9'(rsp_tdata[39:34]))
      else $error("left mix exceeds source levels");

   a_level_step: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[17:16] == 2'b00 && rsp_tdata[23:22] == 2'b00
                     && rsp_tdata[29:28] == 2'b00 && rsp_tdata[35:34] == 2'b00)
      else $error("level not a multiple of four");
endmodule

bind handheld_sound_generator hsg_checker u_hsg_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .req_tuser (req_tuser),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);

>>> verif/handheld_sound_generator_test.sv
// Self-checking bench for handheld_sound_generator: drives register, tick and sample-memory
// items, predicts each tick's mix and levels, and compares them on the result stream.
// Depends on hsg_pkg and the handheld_sound_generator RTL.
`timescale 1ns / 1ps

module handheld_sound_generator_test;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [16:0] address, [24:17] data
   logic [1:0]  req_tuser = hsg_pkg::KIND_NONE;   // [1:0] kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [7:0] left_mix, [15:8] right_mix, [21:16] tone0_level, [27:22] tone1_level,
   // [33:28] sample_level, [39:34] noise_level
   logic [39:0] rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   handheld_sound_generator uut (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   typedef struct {
      bit        on;
      bit [1:0]  wave;
      bit [3:0]  vol;
      bit [15:0] pos;
      bit [15:0] size;
   } tone_type;

   // predictor copy of the block
   bit [3:0]  mute_bits;
   bit        swap_lr;
   bit [15:0] decr_period;
   bit [7:0]  tone_bytes [2][4];
   tone_type  tone_pend [2];
   tone_type  tone_act [2];
   bit [15:0] tone_len [2];
   bit        nz_on, nz_play, nz_left, nz_right;
   bit [3:0]  nz_shift, nz_vol;
   bit [31:0] nz_step, nz_phase;
   bit [15:0] nz_len;
   bit [15:0] nz_lfsr;
   bit        nz_bit;
   bit [7:0]  dma_start_b [2];
   bit [15:0] dma_start;
   bit [31:0] dma_size, dma_bank, dma_pos;
   bit [7:0]  dma_step;
   bit        dma_left, dma_right, dma_on;
   bit [31:0] decr_cnt;
   bit [7:0]  smem [0:131071];
   bit        smem_valid [0:131071];

   hsg_pkg::result_type mix_expected [$];
   int send_idle = 0, recv_idle = 0, hold_cycles = 0;
   int errors = 0, ticks_sent = 0, items_sent = 0, results_seen = 0;

   function automatic void write_tone(int w, int off, bit [7:0] d);
      bit [31:0] raw;
      bit [15:0] keep;
      tone_bytes[w][off] = d;
      if (off <= 1) begin
         raw = {21'd0, tone_bytes[w][1][2:0], tone_bytes[w][0]};
         tone_pend[w].size = (raw != 0) ? 16'((raw + 1) >> 1) : 16'd0;
         tone_pend[w].pos = 0;
         if (tone_len[w] != 0 || tone_act[w].size == 0 || tone_pend[w].size == 0) begin
            tone_act[w].size = tone_pend[w].size;
            if (tone_len[w] == 0) tone_act[w].pos = 0;
         end
      end else if (off == 2) begin
         tone_pend[w].on = d[6];
         tone_pend[w].wave = d[5:4];
         tone_pend[w].vol = d[3:0];
         if (!tone_pend[w].on || tone_act[w].size == 0 || tone_pend[w].size == 0) begin
            keep = tone_act[w].pos;
            tone_act[w] = tone_pend[w];
            if (tone_len[w] != 0) tone_act[w].pos = keep;
         end
      end else begin
         tone_len[w] = 16'(d) + 16'd1;
         tone_act[w].size = tone_pend[w].size;
      end
   endfunction

   function automatic void write_reg(bit [12:0] a, bit [7:0] d);
      if (a >= hsg_pkg::TONE_LO && a <= hsg_pkg::TONE_HI) begin
         write_tone(a[2], a[1:0], d);
      end else if (a >= hsg_pkg::DMA_LO && a <= hsg_pkg::DMA_HI) begin
         case (a[2:0])
            3'd0, 3'd1: begin
               dma_start_b[a[0]] = d;
               dma_start = {dma_start_b[1], dma_start_b[0]};
            end
            3'd2: dma_size = ((d != 0) ? 32'(d) : 32'h100) * 32;
            3'd3: begin
               dma_step = 8'(1 << (3 - d[1:0]));
               dma_right = d[2];
               dma_left = d[3];
               dma_bank = 32'(d[6:4]) << 14;
            end
            default: begin
               dma_on = d[7];
               if (dma_on) dma_pos = 0;
            end
         endcase
      end else if (a >= hsg_pkg::NOISE_LO && a <= hsg_pkg::NOISE_HI) begin
         case (a[1:0])
            2'd0: begin
               nz_step = 32'd1 << (15 - d[7:4]);
               nz_vol = d[3:0];
            end
            2'd1: nz_len = 16'(d) + 16'd1;
            default: begin
               nz_shift = d[0] ? 4'd14 : 4'd6;
               nz_play = d[1];
               nz_right = d[2];
               nz_left = d[3];
               nz_on = d[4];
               nz_lfsr = 1;
            end
         endcase
         nz_phase = 0;
      end
   endfunction

   // index of the sample byte the next tick will read, or -1 when none
   function automatic int next_sample_index();
      bit [31:0] idx, ad;
      if (!dma_on) return -1;
      idx = (dma_pos >> 5) & 32'hffff;
      ad = (32'(dma_start) + idx / 2) & 32'hffff;
      if (ad < 32'h8000 || ad >= 32'hc000) return -1;
      return int'((ad & 32'h3fff) | dma_bank) & 32'h1ffff;
   endfunction

   function automatic hsg_pkg::result_type mix_tick();
      bit [31:0] lmix, rmix, s, thr, sz, st, fb, idx, smp;
      bit [31:0] lv [4];
      int mi;
      hsg_pkg::result_type r;
      lmix = 0; rmix = 0;
      for (int k = 0; k < 4; k++) lv[k] = 0;
      for (int j = 0; j < 2; j++) begin
         if (tone_act[j].size != 0) begin
            if (tone_act[j].on || tone_len[j] != 0) begin
               sz = tone_act[j].size;
               case (tone_act[j].wave)
                  2'd0: thr = (28 * sz) >> 5;
                  2'd1: thr = (24 * sz) >> 5;
                  2'd2: thr = sz / 2;
                  default: thr = sz / 4;
               endcase
               s = (tone_act[j].pos < thr) ? 32'(tone_act[j].vol) << 2 : 0;
               if (!mute_bits[3 - j]) s = 0;
               if (swap_lr) begin
                  if (j == 0) rmix += s; else lmix += s;
               end else begin
                  lmix += s;
                  rmix += s;
               end
               lv[j] = s;
            end
            tone_act[j].pos++;
            if (tone_act[j].pos >= tone_act[j].size) begin
               tone_act[j].pos = 0;
               if (tone_pend[j].on) begin
                  tone_act[j] = tone_pend[j];
                  tone_pend[j].on = 0;
               end
            end
         end
      end
      if (nz_on && (nz_play || nz_len != 0)) begin
         s = (32'(nz_bit) * nz_vol) << 2;
         if (!mute_bits[0]) s = 0;
         if (nz_left) begin lmix += s; lv[3] = s; end
         if (nz_right) begin rmix += s; lv[3] = s; end
         nz_phase += nz_step;
         while (nz_phase >= 4096) begin
            st = nz_lfsr;
            nz_bit = st[0];
            fb = ((st >> 1) ^ st) & 1;
            fb <<= nz_shift;
            nz_lfsr = 16'(((st >> 1) | fb) & 32'h7fff);
            nz_phase -= 4096;
         end
      end
      if (dma_on) begin
         idx = (dma_pos >> 5) & 32'hffff;
         mi = next_sample_index();
         smp = (mi >= 0) ? 32'(smem[mi]) : 0;
         s = idx[0] ? (smp & 4'hf) : ((smp >> 4) & 4'hf);
         s <<= 2;
         if (!mute_bits[1]) s = 0;
         if (dma_left) begin lmix += s; lv[2] = s; end
         if (dma_right) begin rmix += s; lv[2] = s; end
         dma_pos += dma_step;
         if (dma_pos >= (dma_size << 5)) dma_on = 0;
      end
      if (decr_cnt > decr_period) begin
         decr_cnt = 0;
         if (tone_len[0] > 0) tone_len[0]--;
         if (tone_len[1] > 0) tone_len[1]--;
         if (nz_len > 0) nz_len--;
      end
      decr_cnt++;
      r.left = lmix[7:0];
      r.right = rmix[7:0];
      r.tone0 = lv[0][5:0];
      r.tone1 = lv[1][5:0];
      r.sample = lv[2][5:0];
      r.noise = lv[3][5:0];
      return r;
   endfunction

   task automatic send_item(hsg_pkg::kind_type kind, bit [16:0] addr, bit [7:0] data);
      if ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {7'd0, data, addr};
      req_tuser <= kind;
      case (kind)
         hsg_pkg::KIND_REG: write_reg(addr[12:0], data);
         hsg_pkg::KIND_MEM: begin
            smem[addr] = data;
            smem_valid[addr] = 1'b1;
         end
         hsg_pkg::KIND_TICK: begin
            mix_expected.push_back(mix_tick());
            ticks_sent++;
         end
         default: ;
      endcase
      items_sent++;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // a tick never plays a sample byte that was not written first
   task automatic send_tick();
      int mi;
      mi = next_sample_index();
      if (mi >= 0 && !smem_valid[mi])
         send_item(hsg_pkg::KIND_MEM, 17'(mi), 8'($urandom));
      send_item(hsg_pkg::KIND_TICK, 17'($urandom), 8'($urandom));
   endtask

   task automatic send_reg(bit [12:0] a, bit [7:0] d);
      send_item(hsg_pkg::KIND_REG, {4'($urandom), a}, d);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (mix_expected.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, bit [31:0] val);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         hsg_pkg::CSR_MUTE: mute_bits = val[3:0];
         hsg_pkg::CSR_SWAP: swap_lr = val[0];
         hsg_pkg::CSR_DECR: decr_period = val[15:0];
         default: ;
      endcase
   endtask

   task automatic set_config(bit [3:0] mute, bit swap, bit [15:0] period);
      wait_idle();
      csr_write(hsg_pkg::CSR_MUTE, 32'(mute));
      csr_write(hsg_pkg::CSR_SWAP, 32'(swap));
      csr_write(hsg_pkg::CSR_DECR, 32'(period));
   endtask

   task automatic random_item();
      int pick;
      bit [7:0] d;
      pick = $urandom_range(99);
      d = 8'($urandom);
      if (pick < 55) begin
         send_tick();
      end else if (pick < 70) begin
         // tone register: mostly short periods so tones cycle often
         pick = $urandom_range(3);
         if (pick == 1 && $urandom_range(3) != 0) d[2:0] = 0;
         if (pick == 0 && $urandom_range(1) == 0) d = 8'($urandom_range(15));
         if (pick == 3 && $urandom_range(1) == 0) d = 8'($urandom_range(3));
         send_reg(hsg_pkg::TONE_LO + 13'($urandom_range(7) & 4) + 13'(pick), d);
      end else if (pick < 78) begin
         pick = $urandom_range(4);
         // keep plays short except now and then
         if (pick == 2 && $urandom_range(7) != 0) d = 8'($urandom_range(1, 3));
         send_reg(hsg_pkg::DMA_LO + 13'(pick), d);
      end else if (pick < 87) begin
         pick = $urandom_range(2);
         if (pick == 1 && $urandom_range(1) == 0) d = 8'($urandom_range(2));
         send_reg(hsg_pkg::NOISE_LO + 13'(pick), d);
      end else if (pick < 90) begin
         send_reg(13'($urandom), d);   // mostly unmapped
      end else if (pick < 96) begin
         // sample bytes at random addresses
         send_item(hsg_pkg::KIND_MEM, 17'($urandom), d);
      end else begin
         send_item(hsg_pkg::KIND_NONE, 17'($urandom), d);
      end
   endtask

   // well-formed setup: start a tone, the noise and a short play, then run ticks
   task automatic program_sources();
      bit [7:0] hi;
      hi = $urandom_range(1) ? 8'h80 + 8'($urandom_range(63)) : 8'($urandom);
      send_reg(hsg_pkg::TONE_LO + 13'($urandom_range(1) * 4), 8'($urandom_range(1, 40)));
      send_reg(hsg_pkg::TONE_LO + 13'($urandom_range(1) * 4) + 13'd2, 8'($urandom) | 8'h40);
      send_reg(hsg_pkg::NOISE_LO, 8'($urandom));
      send_reg(hsg_pkg::NOISE_LO + 13'd2, 8'($urandom) | 8'h10);
      send_reg(hsg_pkg::DMA_LO, 8'($urandom));
      send_reg(hsg_pkg::DMA_LO + 13'd1, hi);
      send_reg(hsg_pkg::DMA_LO + 13'd2, 8'($urandom_range(1, 4)));
      send_reg(hsg_pkg::DMA_LO + 13'd3, 8'($urandom));
      send_reg(hsg_pkg::DMA_HI, 8'h80);
      repeat ($urandom_range(5, 20)) send_tick();
   endtask

   task automatic run_random(int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(19) == 0) program_sources();
         else random_item();
      end
   endtask

   task automatic test_directed_sources();
      send_tick();                                   // everything idle after reset
      send_reg(hsg_pkg::TONE_LO, 8'd1);              // tone0 raw 1: one-tick period
      send_reg(hsg_pkg::TONE_LO + 13'd1, 8'hff);     // high bits 7, raw 0x701: a long period
      send_reg(hsg_pkg::TONE_LO + 13'd2, 8'h4f);     // on, wave 0, full volume
      send_reg(hsg_pkg::TONE_LO + 13'd7, 8'hff);     // tone1 length at max
      send_reg(hsg_pkg::TONE_LO + 13'd6, 8'h3f);     // tone1 not on, wave 3
      send_tick();
      send_reg(hsg_pkg::NOISE_LO, 8'h0f);            // fastest rate: eight shifts
      send_reg(hsg_pkg::NOISE_LO + 13'd2, 8'h1f);    // on, play, both sides, long tap
      send_tick();
      send_tick();
      send_reg(hsg_pkg::NOISE_LO, 8'hf7);            // slowest rate
      send_reg(hsg_pkg::DMA_LO, 8'hfe);
      send_reg(hsg_pkg::DMA_LO + 13'd1, 8'h7f);      // starts just below the window
      send_reg(hsg_pkg::DMA_LO + 13'd2, 8'h00);      // size 0 means the largest
      send_reg(hsg_pkg::DMA_LO + 13'd3, 8'h7c);      // fastest step, both sides, top bank
      send_reg(hsg_pkg::DMA_HI, 8'h80);
      repeat (4) send_tick();
      send_reg(13'h1fff, 8'hff);                     // unmapped register
      send_item(hsg_pkg::KIND_NONE, 17'h1ffff, 8'hff);   // ignored kind
      send_item(hsg_pkg::KIND_MEM, 17'h1ffff, 8'h5a);
      send_tick();
   endtask

   task automatic test_config_sweep();
      set_config(4'h0, 1'b0, 16'd1);
      program_sources();
      run_random(40);
      set_config(4'hf, 1'b1, 16'hffff);
      program_sources();
      run_random(40);
      for (int b = 0; b < 4; b++) begin
         set_config(4'(1 << b), 1'b0, 16'(1 + $urandom_range(7)));
         program_sources();
         run_random(30);
      end
      set_config(4'($urandom), 1'b1, 16'($urandom_range(1, 300)));
      run_random(40);
      set_config(hsg_pkg::MUTE_RESET, 1'b0, 16'd3);
   endtask

   task automatic test_random_traffic();
      send_idle = 12; recv_idle = 45;
      run_random(160);
      send_idle = 45; recv_idle = 12;
      run_random(160);
      send_idle = 0; recv_idle = 0;
      run_random(120);
   endtask

   task automatic test_backpressure();
      wait_idle();
      send_idle = 0; recv_idle = 0;
      hold_cycles = 400;
      repeat (60) send_tick();
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (mix_expected.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected result %h", rsp_tdata);
            end else begin
               hsg_pkg::result_type want, got;
               want = mix_expected.pop_front();
               got = hsg_pkg::result_type'(rsp_tdata);
               if (got.left !== want.left || got.right !== want.right ||
                   got.tone0 !== want.tone0 || got.tone1 !== want.tone1 ||
                   got.sample !== want.sample || got.noise !== want.noise) begin
                  errors++;
                  if (errors <= 10)
                     $display({"tick %0d: exp L%0d R%0d t0 %0d t1 %0d s %0d n %0d,",
                               " got L%0d R%0d t0 %0d t1 %0d s %0d n %0d"},
                              results_seen, want.left, want.right, want.tone0, want.tone1,
                              want.sample, want.noise, got.left, got.right, got.tone0,
                              got.tone1, got.sample, got.noise);
               end
            end
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle);
         end
      end
   end

   initial begin
      #(4 * 600000);
      $display("handheld_sound_generator_test: errors");
      $finish;
   end

   initial begin
      mute_bits = hsg_pkg::MUTE_RESET;
      swap_lr = 0;
      decr_period = hsg_pkg::DECR_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_sources();
      test_config_sweep();
      test_random_traffic();
      test_backpressure();
      wait_idle();
      if (mix_expected.size() != 0) errors++;
      $display("sent %0d items (%0d ticks), checked %0d mixes across mute, swap and",
               items_sent, ticks_sent, results_seen);
      $display("length-period settings, idle mixes and a long output stall");
      if (errors == 0) begin
         $display("handheld_sound_generator_test: clean");
      end else begin
         $display("handheld_sound_generator_test: errors");
      end
      $finish;
   end

endmodule
